// ===== design/rgbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types, constants and helpers of the RGB convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

	localparam int KMAX        = 5;
	localparam int LINES       = KMAX - 1;
	localparam int HS_MAX      = (KMAX - 1) / 2;
	localparam int COEF_FRAC   = 10;
	localparam int COEF_BITS   = COEF_FRAC + 2;
	localparam int CFG_W       = 60;
	localparam int PIX_W       = 24;
	localparam int PROD_W      = COEF_BITS + 9;
	localparam int ROW_SUM_W   = PROD_W + 3;
	localparam int SUM_W       = ROW_SUM_W + 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int DEF_WIDTH   = 4096;
	localparam int DEF_HEIGHT  = 4096;

	// register indexes of the configuration port
	localparam logic [2:0] REG_COEF_0   = 3'd0;
	localparam logic [2:0] REG_COEF_4   = 3'd4;
	localparam logic [2:0] REG_WIDTH    = 3'd5;
	localparam logic [2:0] REG_HEIGHT   = 3'd6;
	localparam logic [2:0] REG_HALF     = 3'd7;

	typedef struct packed {
		logic       drain;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_in_t;

	typedef struct packed {
		logic       last_of_frame;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} pixel_out_t;

	// window[r][c], pixel packed as {red, green, blue}
	typedef logic [KMAX-1:0][KMAX-1:0][PIX_W-1:0] window_t;
	typedef logic [KMAX-1:0][CFG_W-1:0] coef_bank_t;

	typedef struct packed {
		window_t    win;
		logic       interior;
		logic       last;
		logic [1:0] hs;
	} job_t;

	// coefficient that weights window position (r, c) for a given half size
	function automatic logic signed [COEF_BITS-1:0] coef_sel(coef_bank_t cb,
			logic [1:0] hs, int r, int c);
		int base;
		int dx;
		int dy;
		logic signed [COEF_BITS-1:0] res;
		base = KMAX - 1 - 2 * int'(hs);
		res  = '0;
		if (r >= base && c >= base) begin
			dx  = c - base;
			dy  = r - base;
			res = cb[dx][dy * COEF_BITS +: COEF_BITS];
		end
		return res;
	endfunction

	// truncate toward zero (negative sums clamp to 0), then saturate
	function automatic logic [7:0] clamp_sum(logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] q;
		logic [7:0] res;
		q = s >>> COEF_FRAC;
		if (s <= 0)
			res = 8'd0;
		else if (q > SUM_W'(255))
			res = 8'd255;
		else
			res = q[7:0];
		return res;
	endfunction

endpackage

// ===== design/rgbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/rgbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_front
// Tracks raster positions, keeps the line store and the sliding window, and
// queues one window job for every request that yields an output pixel.
// ----------------------------------------------------------------------------
module rgbc_front import rgbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_WIDTH,
	parameter int MAX_HEIGHT = DEF_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  pixel_in_t  pixel_data,
	input  logic [12:0] frame_width,
	input  logic [12:0] frame_height,
	input  logic [1:0] half_size,
	output logic       job_valid,
	input  logic       job_full,
	output job_t       job
);

	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = HW + 1;
	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int PW    = RW + 2;
	localparam int PRODW = RW + CW + 1;
	localparam int MEM_W = LINES * PIX_W;

	logic [CW-1:0] w;
	logic [HW-1:0] h;
	logic [1:0]    hs;

	logic [CW-1:0] ic_q, oc_q;
	logic [RW-1:0] ir_q, or_q;

	logic [CW-1:0] ic0, ic1, ic2, oc0, oc1, oc2;
	logic [RW-1:0] ir0, ir1, ir2, or0, or1, or2;
	logic          tail, push, clr, produce, interior, last;
	logic [PRODW-1:0] p_idx, lag, o_idx, end_idx;
	logic          accept, retire;

	logic             s1_v_q;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0]    col_s1;
	logic             prod_s1, interior_s1, last_s1;
	logic [1:0]       hs_s1;
	logic             fwd_s1;
	logic [MEM_W-1:0] fwd_data_s1;

	logic [MEM_W-1:0] ram_rd, line_w, wr_word;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	window_t          win_q, win_n;
	logic [PIX_W-1:0] pix_in;

	// effective geometry
	always_comb begin
		if (frame_width == 13'd0)
			w = CW'(1);
		else if ({1'b0, frame_width} > 14'(MAX_WIDTH))
			w = CW'(MAX_WIDTH);
		else
			w = CW'(frame_width);
		if (frame_height == 13'd0)
			h = HW'(1);
		else if ({1'b0, frame_height} > 14'(MAX_HEIGHT))
			h = HW'(MAX_HEIGHT);
		else
			h = HW'(frame_height);
		hs = (half_size > 2'(HS_MAX)) ? 2'(HS_MAX) : half_size;
	end

	// position bookkeeping for the request at the port
	always_comb begin
		ic0 = ic_q;
		ir0 = ir_q;
		if (ic_q >= w) begin
			ic0 = '0;
			ir0 = ir_q + RW'(1);
		end
		oc0 = oc_q;
		or0 = or_q;
		if (oc_q >= w) begin
			oc0 = '0;
			or0 = or_q + RW'(1);
		end
		tail = ir0 >= RW'(h);
		push = !pixel_data.drain || tail;
		clr  = !pixel_data.drain && tail;

		ic1 = clr ? '0 : ic0;
		ir1 = clr ? '0 : ir0;
		oc1 = clr ? '0 : oc0;
		or1 = clr ? '0 : or0;

		p_idx   = PRODW'(ir1) * PRODW'(w) + PRODW'(ic1);
		lag     = PRODW'(hs) * PRODW'(w) + PRODW'(hs);
		produce = push && (p_idx >= lag);

		interior = (PW'(or1) >= PW'(hs)) && (PW'(or1) + PW'(hs) < PW'(h)) &&
			(PW'(oc1) >= PW'(hs)) && (PW'(oc1) + PW'(hs) < PW'(w));
		o_idx   = PRODW'(or1) * PRODW'(w) + PRODW'(oc1);
		end_idx = PRODW'(h) * PRODW'(w) - PRODW'(1);
		last    = o_idx >= end_idx;

		ic2 = ic1 + CW'(1);
		ir2 = ir1;
		if (ic2 >= w) begin
			ic2 = '0;
			ir2 = ir1 + RW'(1);
		end
		oc2 = oc1 + CW'(1);
		or2 = or1;
		if (oc2 >= w) begin
			oc2 = '0;
			or2 = or1 + RW'(1);
		end
	end

	assign retire      = s1_v_q && (!prod_s1 || !job_full);
	assign pixel_stall = s1_v_q && !retire;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (accept) begin
			if (produce && last) begin
				ic_q <= '0;
				ir_q <= '0;
				oc_q <= '0;
				or_q <= '0;
			end else if (push) begin
				ic_q <= ic2;
				ir_q <= ir2;
				oc_q <= produce ? oc2 : oc1;
				or_q <= produce ? or2 : or1;
			end else begin
				ic_q <= ic0;
				ir_q <= ir0;
				oc_q <= oc0;
				or_q <= or0;
			end
		end
	end

	assign pix_in  = pixel_data.drain ? '0 :
		{pixel_data.pixel_red, pixel_data.pixel_green, pixel_data.pixel_blue};
	assign rd_en   = accept && push;
	assign rd_addr = ic1[AW-1:0];

	// line store word holds line k at bits k*PIX_W; a new column shifts it down
	assign line_w  = fwd_s1 ? fwd_data_s1 : ram_rd;
	assign wr_word = {line_w[MEM_W-PIX_W-1:0], pix_s1};

	rgbc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (retire),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (accept)
			s1_v_q <= push;
		else if (retire)
			s1_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pix_s1      <= pix_in;
			col_s1      <= rd_addr;
			prod_s1     <= produce;
			interior_s1 <= interior;
			last_s1     <= last;
			hs_s1       <= hs;
			// write to the same column in the read cycle: take the written word
			fwd_s1      <= retire && (col_s1 == rd_addr);
			fwd_data_s1 <= wr_word;
		end
	end

	always_comb begin
		for (int r = 0; r < KMAX; r++) begin
			for (int c = 0; c < KMAX - 1; c++)
				win_n[r][c] = win_q[r][c+1];
		end
		win_n[KMAX-1][KMAX-1] = pix_s1;
		for (int k = 0; k < LINES; k++)
			win_n[KMAX-2-k][KMAX-1] = line_w[k*PIX_W +: PIX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (retire)
			win_q <= win_n;
	end

	assign job_valid    = retire && prod_s1;
	assign job.win      = win_n;
	assign job.interior = interior_s1;
	assign job.last     = last_s1;
	assign job.hs       = hs_s1;

`ifndef NO_ASSERTIONS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !retire |=> s1_v_q && $stable(col_s1))
		else $error("stage 1 request lost while stalled");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && produce && last |=> ic_q == '0 && oc_q == '0 && or_q == '0)
		else $error("positions not cleared after frame end");
`endif

endmodule

// ===== design/rgbc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_queue
// Short job queue between window builder and arithmetic pipeline.
// ----------------------------------------------------------------------------
module rgbc_queue import rgbc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = entry_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || do_pop)
		else $error("job queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("job queue count out of range");
`endif

endmodule

// ===== design/rgbc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbc_back
// Three-stage multiply / row-sum / total pipeline with clamp and pass-through.
// ----------------------------------------------------------------------------
module rgbc_back import rgbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_pop,
	input  coef_bank_t coefs,
	output logic       result_valid,
	input  logic       result_stall,
	output pixel_out_t result_data
);

	logic adv;

	logic                    v_s1, v_s2;
	logic signed [PROD_W-1:0] prod_s1 [3][KMAX][KMAX];
	logic [PIX_W-1:0]        center_s1, center_s2;
	logic                    interior_s1, interior_s2, last_s1, last_s2;
	logic signed [ROW_SUM_W-1:0] rsum_s2 [3][KMAX];

	logic signed [PROD_W-1:0]    prod_n [3][KMAX][KMAX];
	logic signed [ROW_SUM_W-1:0] rsum_n [3][KMAX];
	logic signed [SUM_W-1:0]     tot_n [3];
	logic [2:0]                  cidx;
	logic [7:0]                  pix8;
	logic signed [COEF_BITS-1:0] cf;

	assign adv     = !(result_valid && result_stall);
	assign job_pop = adv && job_valid;
	assign cidx    = 3'(KMAX - 1) - 3'(job.hs);

	always_comb begin
		for (int r = 0; r < KMAX; r++) begin
			for (int c = 0; c < KMAX; c++) begin
				cf = coef_sel(coefs, job.hs, r, c);
				for (int ch = 0; ch < 3; ch++) begin
					pix8 = job.win[r][c][ch*8 +: 8];
					prod_n[ch][r][c] = PROD_W'($signed({1'b0, pix8}) * cf);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < KMAX; r++) begin
				rsum_n[ch][r] = '0;
				for (int c = 0; c < KMAX; c++)
					rsum_n[ch][r] = rsum_n[ch][r] + ROW_SUM_W'(prod_s1[ch][r][c]);
			end
			tot_n[ch] = '0;
			for (int r = 0; r < KMAX; r++)
				tot_n[ch] = tot_n[ch] + SUM_W'(rsum_s2[ch][r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			v_s1         <= job_valid;
			v_s2         <= v_s1;
			result_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1     <= prod_n;
			center_s1   <= job.win[cidx][cidx];
			interior_s1 <= job.interior;
			last_s1     <= job.last;
			rsum_s2     <= rsum_n;
			center_s2   <= center_s1;
			interior_s2 <= interior_s1;
			last_s2     <= last_s1;
			result_data.last_of_frame <= last_s2;
			if (interior_s2) begin
				result_data.out_blue  <= clamp_sum(tot_n[0]);
				result_data.out_green <= clamp_sum(tot_n[1]);
				result_data.out_red   <= clamp_sum(tot_n[2]);
			end else begin
				result_data.out_blue  <= center_s2[7:0];
				result_data.out_green <= center_s2[15:8];
				result_data.out_red   <= center_s2[23:16];
			end
		end
	end

endmodule

// ===== design/rgb_image_convolution.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_image_convolution
// Per-channel 2-D convolution (up to 5x5) over a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Result path: the request completing a window (half_size rows plus half_size
//   pixels behind it) passes the front register, job queue and back pipeline.
// Throughput: one request per cycle when not stalled; a 2-entry job queue
//   decouples line store and multiply pipeline so each side stalls on its own.
// Reset: positions and window cleared, registers to defaults; line store is
//   not cleared, no clearing pass.
module rgb_image_convolution import rgbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_WIDTH,
	parameter int MAX_HEIGHT = DEF_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  pixel_in_t        pixel_data,
	output logic             result_valid,
	input  logic             result_stall,
	output pixel_out_t       result_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	coef_bank_t  coefs_q;
	logic [12:0] frame_width_q, frame_height_q;
	logic [1:0]  half_size_q;

	logic job_push, job_full, job_avail, job_pop;
	job_t job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q        <= '0;
			frame_width_q  <= 13'd640;
			frame_height_q <= 13'd480;
			half_size_q    <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_index) inside
				[REG_COEF_0:REG_COEF_4]: coefs_q[cfg_index] <= cfg_data;
				REG_WIDTH:  frame_width_q  <= cfg_data[12:0];
				REG_HEIGHT: frame_height_q <= cfg_data[12:0];
				REG_HALF:   half_size_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	rgbc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_data   (pixel_data),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.half_size    (half_size_q),
		.job_valid    (job_push),
		.job_full     (job_full),
		.job          (job_in)
	);

	rgbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.not_empty (job_avail),
		.head      (job_out)
	);

	rgbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_avail),
		.job          (job_out),
		.job_pop      (job_pop),
		.coefs        (coefs_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
